// ===== hdl/lkvc_pkg.sv =====
// lkvc_pkg: shared constants, codes and types of the lru key-value cache
// used by lkvc_store and lru_key_value_cache; no dependencies
package lkvc_pkg;

    // default number of entries
    localparam int MAX_ENTRIES_DEF = 16;

    // field widths fixed by the request format
    localparam int KEY_W  = 8;
    localparam int DATA_W = 8;
    localparam int CAP_W  = 5;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [DATA_W-1:0] t_data;

endpackage

// ===== hdl/lkvc_store.sv =====
// lkvc_store: key, data and recency rank memories of the cache
// one shared read address with registered read data; needs lkvc_pkg
module lkvc_store #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic [IW-1:0]     i_rd_addr,
    output lkvc_pkg::t_key    o_key,
    output lkvc_pkg::t_data   o_data,
    output logic [IW-1:0]     o_rank,
    input  logic              i_kv_we,
    input  logic [IW-1:0]     i_kv_addr,
    input  lkvc_pkg::t_key    i_key,
    input  lkvc_pkg::t_data   i_data,
    input  logic              i_rank_we,
    input  logic [IW-1:0]     i_rank_addr,
    input  logic [IW-1:0]     i_rank
);

    lkvc_pkg::t_key  r_key_mem  [MAX_ENTRIES];
    lkvc_pkg::t_data r_data_mem [MAX_ENTRIES];
    logic [IW-1:0]   r_rank_mem [MAX_ENTRIES];

    lkvc_pkg::t_key  r_key_q;
    lkvc_pkg::t_data r_data_q;
    logic [IW-1:0]   r_rank_q;

    // key and data: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_kv_we) begin
            r_key_mem[i_kv_addr]  <= i_key;
            r_data_mem[i_kv_addr] <= i_data;
        end
        r_key_q  <= r_key_mem[i_rd_addr];
        r_data_q <= r_data_mem[i_rd_addr];
    end

    // recency ranks: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_rank_we) begin
            r_rank_mem[i_rank_addr] <= i_rank;
        end
        r_rank_q <= r_rank_mem[i_rd_addr];
    end

    assign o_key  = r_key_q;
    assign o_data = r_data_q;
    assign o_rank = r_rank_q;

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key-value cache with lru replacement
// a sequencer walks the store one entry a cycle; needs lkvc_pkg and lkvc_store
// a get miss runs the search walk only, other requests also run the rank update walk
// the next request is taken only after the result is handed off, later while a held result
//   blocks the hand-off; both walks share the one store read port
// reset: synchronous active low; empties the cache and sets capacity to 16
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_operation,
    input  lkvc_pkg::t_key             i_key,
    input  lkvc_pkg::t_data            i_data,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output lkvc_pkg::t_data            o_read_data
);

    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPD,
        S_FIN
    } t_state;

    t_state                     r_state;
    logic [lkvc_pkg::CAP_W-1:0] r_capacity;
    logic [MAX_ENTRIES-1:0]     r_valid;
    logic [OCC_W-1:0]           r_occupancy;

    // walk control
    logic [IW-1:0]   r_addr;
    logic            r_issue;
    logic            r_pv;
    logic [IW-1:0]   r_pidx;

    // captured request
    logic            r_op;
    lkvc_pkg::t_key  r_key;
    lkvc_pkg::t_data r_data;

    // search results
    logic            r_found;
    logic [IW-1:0]   r_fslot;
    logic [IW-1:0]   r_frank;
    lkvc_pkg::t_data r_fval;
    logic            r_free_ok;
    logic [IW-1:0]   r_free_slot;
    logic            r_vict_ok;
    logic [IW-1:0]   r_vict_slot;

    // rank update plan
    logic [IW-1:0]   r_slot;
    logic [IW-1:0]   r_thresh;
    logic            r_all;

    // pending result and output register
    logic            r_res_hit;
    lkvc_pkg::t_data r_res_data;
    logic            r_o_valid;
    logic            r_o_hit;
    lkvc_pkg::t_data r_o_data;

    // store read data
    lkvc_pkg::t_key  mem_key;
    lkvc_pkg::t_data mem_data;
    logic [IW-1:0]   mem_rank;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic             full;
    logic             cur_valid;
    logic             key_match;
    logic             is_victim;
    logic [IW-1:0]    dec_slot;
    logic             kv_we;
    logic             rank_we;
    logic [IW-1:0]    upd_rank;
    logic             out_free;

    // effective capacity: zero acts as one, large values clip to the store size
    always_comb begin
        cap_ext = CMP_W'(r_capacity);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = CMP_W'(r_occupancy) >= eff_cap;
    end

    // shared compare unit on the entry coming out of the store
    always_comb begin
        cur_valid = r_valid[r_pidx];
        key_match = cur_valid && (mem_key == r_key);
        is_victim = cur_valid && ((OCC_W'(mem_rank) + OCC_W'(1)) == r_occupancy);
    end

    // target slot: the hit entry, else the lru victim when full, else a free slot
    always_comb begin
        if (r_found) begin
            dec_slot = r_fslot;
        end else if (full) begin
            dec_slot = r_vict_slot;
        end else begin
            dec_slot = r_free_slot;
        end
    end

    // new rank of the entry on the update walk
    always_comb begin
        if (r_pidx == r_slot) begin
            upd_rank = '0;
        end else if (cur_valid && (r_all || (mem_rank < r_thresh))) begin
            upd_rank = mem_rank + IW'(1);
        end else begin
            upd_rank = mem_rank;
        end
    end

    assign kv_we    = (r_state == S_DECIDE) && (r_op == lkvc_pkg::OP_SET);
    assign rank_we  = (r_state == S_UPD) && r_pv;
    assign out_free = !r_o_valid || i_ready;

    lkvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (r_addr),
        .o_key       (mem_key),
        .o_data      (mem_data),
        .o_rank      (mem_rank),
        .i_kv_we     (kv_we),
        .i_kv_addr   (dec_slot),
        .i_key       (r_key),
        .i_data      (r_data),
        .i_rank_we   (rank_we),
        .i_rank_addr (r_pidx),
        .i_rank      (upd_rank)
    );

    // sequencer: search walk, decision, rank update walk, result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= lkvc_pkg::CAP_RESET;
            r_valid     <= '0;
            r_occupancy <= '0;
            r_issue     <= 1'b0;
            r_pv        <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            // result taken downstream, a new one is loaded below instead
            if (r_o_valid && i_ready && (r_state != S_FIN)) begin
                r_o_valid <= 1'b0;
            end

            // walk address generation, shared by both walks
            if (r_issue) begin
                if (r_addr == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + IW'(1);
                end
            end
            r_pv   <= r_issue;
            r_pidx <= r_addr;

            case (r_state)
                S_IDLE: begin
                    // capacity write empties the store
                    if (i_cfg_we) begin
                        r_capacity  <= i_cfg_wdata;
                        r_valid     <= '0;
                        r_occupancy <= '0;
                    end
                    if (i_valid) begin
                        r_op      <= i_operation;
                        r_key     <= i_key;
                        r_data    <= i_data;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_vict_ok <= 1'b0;
                        r_addr    <= '0;
                        r_issue   <= 1'b1;
                        r_state   <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (r_pv) begin
                        if (key_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fslot <= r_pidx;
                            r_frank <= mem_rank;
                            r_fval  <= mem_data;
                        end
                        if (!cur_valid && !r_free_ok) begin
                            r_free_ok   <= 1'b1;
                            r_free_slot <= r_pidx;
                        end
                        if (is_victim && !r_vict_ok) begin
                            r_vict_ok   <= 1'b1;
                            r_vict_slot <= r_pidx;
                        end
                        if (r_pidx == LAST_IDX) begin
                            r_state <= S_DECIDE;
                        end
                    end
                    // victim defaults to slot zero if none was seen
                    if (r_state == S_SCAN && !r_vict_ok && !r_pv) begin
                        r_vict_slot <= '0;
                    end
                end

                S_DECIDE: begin
                    r_slot     <= dec_slot;
                    r_res_hit  <= r_found;
                    r_res_data <= (r_found && (r_op == lkvc_pkg::OP_GET)) ? r_fval : '0;
                    r_addr     <= '0;
                    if (r_found) begin
                        // promote the hit entry
                        r_thresh <= r_frank;
                        r_all    <= 1'b0;
                        r_issue  <= 1'b1;
                        r_state  <= S_UPD;
                    end else if (r_op == lkvc_pkg::OP_GET) begin
                        // get miss leaves the store as it is
                        r_state <= S_FIN;
                    end else if (full) begin
                        // replace the least recent entry
                        r_thresh <= IW'(r_occupancy - OCC_W'(1));
                        r_all    <= 1'b0;
                        r_issue  <= 1'b1;
                        r_state  <= S_UPD;
                    end else begin
                        // insert into a free slot, every valid entry ages
                        r_valid[dec_slot] <= 1'b1;
                        r_occupancy       <= r_occupancy + OCC_W'(1);
                        r_thresh          <= '0;
                        r_all             <= 1'b1;
                        r_issue           <= 1'b1;
                        r_state           <= S_UPD;
                    end
                end

                S_UPD: begin
                    if (r_pv && (r_pidx == LAST_IDX)) begin
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_hit   <= r_res_hit;
                        r_o_data  <= r_res_data;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_hit       = r_o_hit;
    assign o_read_data = r_o_data;

endmodule

// ===== dv/tb_lru_key_value_cache.sv =====
// tb_lru_key_value_cache: self-checking testbench of the lru key-value cache
// predicts hit and read data for every request; needs lkvc_pkg and lru_key_value_cache
module tb_lru_key_value_cache;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ENTRIES     = lkvc_pkg::MAX_ENTRIES_DEF;
    localparam int          CAP_W       = lkvc_pkg::CAP_W;
    localparam int          DRAIN_WAIT  = 2 * ENTRIES + 8;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic            hit;
        lkvc_pkg::t_data read_data;
    } t_lookup_result;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;
    logic            i_valid;
    logic            o_ready;
    logic            i_operation;
    lkvc_pkg::t_key  i_key;
    lkvc_pkg::t_data i_data;
    logic            o_valid;
    logic            i_ready;
    logic            o_hit;
    lkvc_pkg::t_data o_read_data;

    // predicted cache contents
    lkvc_pkg::t_key  cache_key   [ENTRIES];
    lkvc_pkg::t_data cache_value [ENTRIES];
    bit              cache_valid [ENTRIES];
    int unsigned     cache_rank  [ENTRIES];
    int unsigned     cache_count;
    logic [CAP_W-1:0] capacity_reg;

    t_lookup_result  pending_results[$];
    int unsigned     error_count     = 0;
    int unsigned     requests_sent;
    int unsigned     results_checked = 0;
    int unsigned     capacity_writes;
    int unsigned     cycle_count;

    // sender and receiver pacing
    bit              back_to_back;
    bit              ready_steady;
    bit              hold_off_req;

    lru_key_value_cache uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_read_data (o_read_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // cache predictor
    // ---------------------------------------------------------------

    // entries in use after clamping the register to 1..ENTRIES
    function automatic int unsigned cap_in_use();
        int unsigned c;
        c = 32'(capacity_reg);
        if (c < 1) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    function automatic void clear_cache();
        for (int i = 0; i < ENTRIES; i++) begin
            cache_valid[i] = 1'b0;
            cache_rank[i]  = 0;
        end
        cache_count = 0;
    endfunction

    // younger entries age by one, slot becomes most recent
    function automatic void make_recent(input int slot);
        int unsigned r;
        r = cache_rank[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i] && cache_rank[i] < r) cache_rank[i]++;
        end
        cache_rank[slot] = 0;
    endfunction

    function automatic t_lookup_result predict_access(input logic op,
                                                      input lkvc_pkg::t_key key,
                                                      input lkvc_pkg::t_data data);
        t_lookup_result res;
        int             found;
        int             slot;
        res.hit       = 1'b0;
        res.read_data = '0;
        found         = -1;
        slot          = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && cache_valid[i] && cache_key[i] == key) found = i;
        end
        // lookup
        if (op == lkvc_pkg::OP_GET) begin
            if (found >= 0) begin
                res.hit       = 1'b1;
                res.read_data = cache_value[found];
                make_recent(found);
            end
            return res;
        end
        // update of a present key
        if (found >= 0) begin
            res.hit            = 1'b1;
            cache_value[found] = data;
            make_recent(found);
            return res;
        end
        if (cache_count >= cap_in_use()) begin
            // full: replace the least recent entry
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && cache_valid[i] && cache_rank[i] + 1 == cache_count) slot = i;
            end
            if (slot < 0) slot = 0;
            cache_key[slot]   = key;
            cache_value[slot] = data;
            make_recent(slot);
        end else begin
            // insert into the first free slot, everyone else ages
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && !cache_valid[i]) slot = i;
            end
            if (slot < 0) slot = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (cache_valid[i]) cache_rank[i]++;
            end
            cache_valid[slot] = 1'b1;
            cache_key[slot]   = key;
            cache_value[slot] = data;
            cache_rank[slot]  = 0;
            cache_count++;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: hit %0d read_data %0h", o_hit, o_read_data);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (o_hit !== exp_res.hit) begin
                    $error("hit: expected %0d, actual %0d", exp_res.hit, o_hit);
                    error_count++;
                end
                if (o_read_data !== exp_res.read_data) begin
                    $error("read_data: expected %0h, actual %0h", exp_res.read_data,
                           o_read_data);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random stalls, steady stretches, long hold-off
    // ---------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned len;
        bit          hold_done;
        i_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_ready   = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (ready_steady) begin
                i_ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_ready = 1'b1;
                end else begin
                    i_ready = 1'b0;
                    len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                    repeat (len - 1) @(negedge i_clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (back_to_back || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic op, input lkvc_pkg::t_key key,
                                input lkvc_pkg::t_data data);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_operation = op;
        i_key       = key;
        i_data      = data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_access(op, key, data));
        requests_sent++;
    endtask

    // wait for every result, then let the sequencer settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // capacity write, only with the cache idle; clears the store
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we     = 1'b1;
        i_cfg_wdata  = value;
        capacity_reg = value;
        clear_cache();
        capacity_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // lookups on an empty cache miss
    task automatic test_empty_miss();
        send_request(lkvc_pkg::OP_GET, 8'h00, 8'hFF);
        send_request(lkvc_pkg::OP_GET, 8'hFF, 8'h00);
    endtask

    // insert, hit, update of a present key
    task automatic test_set_get();
        send_request(lkvc_pkg::OP_SET, 8'h00, 8'hFF);
        send_request(lkvc_pkg::OP_SET, 8'hFF, 8'h00);
        send_request(lkvc_pkg::OP_GET, 8'h00, 8'h00);
        send_request(lkvc_pkg::OP_GET, 8'hFF, 8'hFF);
        send_request(lkvc_pkg::OP_SET, 8'h00, 8'h5A);
        send_request(lkvc_pkg::OP_GET, 8'h00, 8'h00);
    endtask

    // least recent entry is replaced once full
    task automatic test_eviction();
        write_capacity(5'd2);
        send_request(lkvc_pkg::OP_SET, 8'h10, 8'hA1);
        send_request(lkvc_pkg::OP_SET, 8'h20, 8'hA2);
        send_request(lkvc_pkg::OP_SET, 8'h30, 8'hA3);
        send_request(lkvc_pkg::OP_GET, 8'h10, 8'h00);
        send_request(lkvc_pkg::OP_GET, 8'h20, 8'h00);
        send_request(lkvc_pkg::OP_SET, 8'h40, 8'hA4);
        send_request(lkvc_pkg::OP_GET, 8'h30, 8'h00);
    endtask

    // zero acts as one entry, values above the store act as full size
    task automatic test_capacity_extremes();
        write_capacity(5'd0);
        send_request(lkvc_pkg::OP_SET, 8'h55, 8'h11);
        send_request(lkvc_pkg::OP_SET, 8'hAA, 8'h22);
        send_request(lkvc_pkg::OP_GET, 8'h55, 8'h00);
        send_request(lkvc_pkg::OP_GET, 8'hAA, 8'h00);
        write_capacity(5'd31);
        send_request(lkvc_pkg::OP_GET, 8'hAA, 8'h00);
        send_request(lkvc_pkg::OP_SET, 8'hC3, 8'h3C);
        send_request(lkvc_pkg::OP_GET, 8'hC3, 8'h00);
    endtask

    // random traffic over a window of keys a bit wider than the capacity
    task automatic test_random_traffic();
        logic [CAP_W-1:0] cap_list[10];
        int unsigned      pool;
        lkvc_pkg::t_key   base;
        lkvc_pkg::t_key   key;
        logic             op;
        cap_list = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd17, 5'd8, 5'd2, 5'd16, 5'd3};
        for (int phase = 0; phase < 10; phase++) begin
            write_capacity((phase == 6) ? CAP_W'($urandom_range(0, 31)) : cap_list[phase]);
            back_to_back = ($urandom_range(0, 3) == 0);
            ready_steady = ($urandom_range(0, 3) == 0);
            base = lkvc_pkg::t_key'($urandom_range(0, 255));
            pool = cap_in_use() + $urandom_range(0, 4);
            for (int n = 0; n < 95; n++) begin
                op = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 85)
                    key = base + lkvc_pkg::t_key'($urandom_range(0, pool - 1));
                else
                    key = lkvc_pkg::t_key'($urandom_range(0, 255));
                send_request(op, key, lkvc_pkg::t_data'($urandom_range(0, 255)));
            end
        end
        back_to_back = 1'b0;
        ready_steady = 1'b0;
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        write_capacity(lkvc_pkg::CAP_RESET);
        back_to_back = 1'b1;
        hold_off_req = 1'b1;
        for (int n = 0; n < 24; n++) begin
            send_request(1'($urandom_range(0, 1)), lkvc_pkg::t_key'($urandom_range(0, 19)),
                         lkvc_pkg::t_data'($urandom_range(0, 255)));
        end
        back_to_back = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_operation     = lkvc_pkg::OP_GET;
        i_key           = '0;
        i_data          = '0;
        requests_sent   = 0;
        capacity_writes = 0;
        back_to_back    = 1'b0;
        ready_steady    = 1'b0;
        hold_off_req    = 1'b0;
        capacity_reg    = lkvc_pkg::CAP_RESET;
        clear_cache();

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (DRAIN_WAIT) @(posedge i_clk);

        test_empty_miss();
        test_set_get();
        test_eviction();
        test_capacity_extremes();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        $display("run covered %0d requests and %0d checked results", requests_sent,
                 results_checked);
        $display("across %0d capacity settings, with stalls on both sides", capacity_writes);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lkvc_pkg.sv
hdl/lkvc_store.sv
hdl/lru_key_value_cache.sv
dv/tb_lru_key_value_cache.sv
